// ===== rtl/record_sorter_three_key_macros.svh =====
// Assertion macros for the record sorter top level.
`ifndef RECORD_SORTER_THREE_KEY_MACROS_SVH
`define RECORD_SORTER_THREE_KEY_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RSK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rsk_pkg.sv =====
// Package: record types, command group and sort-key compare for the record sorter.
package rsk_pkg;

    localparam int REC_MAX_DEF = 32;

    typedef struct packed {
        logic [3:0]  lane_id;
        logic [3:0]  car_id;
        logic [15:0] stamp;
        logic [6:0]  pos_x;
        logic [5:0]  pos_y;
        logic        last_record;
    } t_rec_in;

    typedef struct packed {
        logic [3:0]  out_lane_id;
        logic [3:0]  out_car_id;
        logic [15:0] out_stamp;
        logic [6:0]  out_pos_x;
        logic [5:0]  out_pos_y;
        logic        out_last;
        logic        overflow;
    } t_rec_out;

    // Stored record, without the end-of-set flag
    typedef struct packed {
        logic [3:0]  lane_id;
        logic [3:0]  car_id;
        logic [15:0] stamp;
        logic [6:0]  pos_x;
        logic [5:0]  pos_y;
    } t_rec;

    typedef struct packed {
        logic load_wr;    // store the incoming record
        logic rd_en;      // read the store
        logic load_best;  // read data opens a new pass
        logic cmp;        // read data competes against the current best
        logic emit;       // emit best, write displaced record back
        logic last;       // emitted record closes the set
        logic ovf;        // records were dropped from this set
    } t_dp_cmd;

    // a strictly before b: lane up, car up, stamp down
    function automatic logic rec_before(input t_rec a, input t_rec b);
        if (a.lane_id != b.lane_id) begin
            return a.lane_id < b.lane_id;
        end
        if (a.car_id != b.car_id) begin
            return a.car_id < b.car_id;
        end
        return a.stamp > b.stamp;
    endfunction

endpackage

// ===== rtl/rsk_dp.sv =====
// Datapath: record store, read register, best-candidate registers and result register.
module rsk_dp
    import rsk_pkg::*;
#(
    parameter int MAX_RECORDS = REC_MAX_DEF,
    localparam int IW = $clog2(MAX_RECORDS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_dp_cmd         i_cmd,
    input  logic [IW-1:0]   i_wr_addr,
    input  logic [IW-1:0]   i_rd_addr,
    input  t_rec_in         i_item,
    output logic            o_valid,
    output t_rec_out        o_result
);

    t_rec           r_mem [MAX_RECORDS];
    t_rec           r_rd_q;
    logic [IW-1:0]  r_rd_idx;
    t_rec           r_best;
    t_rec           r_cur;
    logic [IW-1:0]  r_best_idx;
    logic           r_valid;
    t_rec_out       r_out;

    logic           s_wr_en;
    logic [IW-1:0]  s_wr_addr;
    t_rec           s_wr_data;
    t_rec           s_item_rec;

    assign s_item_rec = '{lane_id: i_item.lane_id, car_id: i_item.car_id,
                          stamp: i_item.stamp, pos_x: i_item.pos_x, pos_y: i_item.pos_y};

    // one write port: loads during collection, swap write-back at emit
    always_comb begin
        s_wr_en   = i_cmd.load_wr | i_cmd.emit;
        s_wr_addr = i_cmd.load_wr ? i_wr_addr : r_best_idx;
        s_wr_data = i_cmd.load_wr ? s_item_rec : r_cur;
    end

    always_ff @(posedge i_clk) begin
        if (s_wr_en) begin
            r_mem[s_wr_addr] <= s_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_q   <= r_mem[i_rd_addr];
            r_rd_idx <= i_rd_addr;
        end
    end

    // earliest strict minimum wins, so ties keep the lower index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_best) begin
            r_best     <= r_rd_q;
            r_cur      <= r_rd_q;
            r_best_idx <= r_rd_idx;
        end else if (i_cmd.cmp && rec_before(r_rd_q, r_best)) begin
            r_best     <= r_rd_q;
            r_best_idx <= r_rd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= '{out_lane_id: r_best.lane_id, out_car_id: r_best.car_id,
                       out_stamp: r_best.stamp, out_pos_x: r_best.pos_x,
                       out_pos_y: r_best.pos_y, out_last: i_cmd.last,
                       overflow: i_cmd.ovf};
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/rsk_ctrl.sv =====
// Controller: collection count, overflow flag and selection-sort sequencer.
module rsk_ctrl
    import rsk_pkg::*;
#(
    parameter int MAX_RECORDS = REC_MAX_DEF,
    localparam int CW = $clog2(MAX_RECORDS + 1),
    localparam int IW = $clog2(MAX_RECORDS)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_last,
    output logic            o_busy,
    output t_dp_cmd         o_cmd,
    output logic [IW-1:0]   o_wr_addr,
    output logic [IW-1:0]   o_rd_addr
);

    typedef enum logic [4:0] {
        ST_LOAD  = 5'b00001,
        ST_FETCH = 5'b00010,
        ST_PRIME = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_EMIT  = 5'b10000
    } t_state;

    t_state         r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic           r_ovf, n_ovf;
    logic [IW-1:0]  r_i, n_i;
    logic [CW-1:0]  r_j, n_j;

    logic [CW-1:0]  s_i_plus1;
    logic           s_last_pass;

    assign s_i_plus1   = CW'(r_i) + CW'(1);
    assign s_last_pass = (s_i_plus1 == r_cnt);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_ovf     = r_ovf;
        n_i       = r_i;
        n_j       = r_j;
        o_cmd     = '0;
        o_rd_addr = r_i;
        unique case (r_state)
            ST_LOAD: begin
                if (i_start) begin
                    if (r_cnt < CW'(MAX_RECORDS)) begin
                        o_cmd.load_wr = 1'b1;
                        n_cnt         = r_cnt + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_last) begin
                        n_i     = '0;
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                o_cmd.rd_en = 1'b1;
                o_rd_addr   = r_i;
                n_state     = ST_PRIME;
            end
            ST_PRIME: begin
                // record i is now in the read register; start scanning from i+1
                o_cmd.load_best = 1'b1;
                if (s_i_plus1 < r_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = s_i_plus1[IW-1:0];
                    n_j         = CW'(r_i) + CW'(2);
                    n_state     = ST_SCAN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SCAN: begin
                o_cmd.cmp = 1'b1;
                if (r_j < r_cnt) begin
                    o_cmd.rd_en = 1'b1;
                    o_rd_addr   = r_j[IW-1:0];
                    n_j         = r_j + CW'(1);
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                o_cmd.emit = 1'b1;
                o_cmd.last = s_last_pass;
                o_cmd.ovf  = r_ovf;
                if (s_last_pass) begin
                    n_cnt   = '0;
                    n_ovf   = 1'b0;
                    n_state = ST_LOAD;
                end else begin
                    n_i     = r_i + IW'(1);
                    n_state = ST_FETCH;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_ovf   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ovf   <= n_ovf;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

    assign o_busy    = (r_state != ST_LOAD);
    assign o_wr_addr = r_cnt[IW-1:0];

endmodule

// ===== rtl/record_sorter_three_key.sv =====
// Top level: collects a record set, selection-sorts it on lane/car/stamp, emits it in order.
//
//  channel   | handshake            | payload
//  ----------+----------------------+------------------------------
//  record in | start high, busy low | i_item   (t_rec_in)
//  result    | o_valid, one cycle   | o_result (t_rec_out)
//
// Collection accepts a record whenever start is high and busy is low. After the
// last record of a set of n, each pass i runs fetch, prime, scan and emit through
// the single read port of the store. Result k leaves on pass k; busy falls as the
// final result is registered.
// Reset is synchronous and clears control state only; there is no clearing pass.
// The receiver cannot stall: each result is valid for exactly one cycle.
module record_sorter_three_key
    import rsk_pkg::*;
#(
    parameter int MAX_RECORDS = REC_MAX_DEF,
    localparam int IW = $clog2(MAX_RECORDS)
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_rec_in   i_item,
    output logic      o_valid,
    output t_rec_out  o_result
);

    `include "record_sorter_three_key_macros.svh"

    t_dp_cmd        s_cmd;
    logic [IW-1:0]  s_wr_addr;
    logic [IW-1:0]  s_rd_addr;

    rsk_ctrl #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_last    (i_item.last_record),
        .o_busy    (busy),
        .o_cmd     (s_cmd),
        .o_wr_addr (s_wr_addr),
        .o_rd_addr (s_rd_addr)
    );

    rsk_dp #(
        .MAX_RECORDS (MAX_RECORDS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (s_cmd),
        .i_wr_addr (s_wr_addr),
        .i_rd_addr (s_rd_addr),
        .i_item    (i_item),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

    // a transaction without the last flag never produces a result
    `RSK_ASSERT_NEXT(a_no_result_mid_set, start && !busy && !i_item.last_record, !o_valid, "result after a mid-set transaction")
    // end of set always starts the sort
    `RSK_ASSERT_NEXT(a_last_starts_sort, start && !busy && i_item.last_record, busy, "sort did not start on last record")
    // final result coincides with return to collection
    `RSK_ASSERT_NOW(a_final_frees, o_valid && o_result.out_last, !busy, "busy still high with final result")
    // every earlier result leaves while the sort still runs
    `RSK_ASSERT_NOW(a_mid_busy, o_valid && !o_result.out_last, busy, "sorter idle with results pending")

endmodule

// ===== tb/tb.sv =====
// Self-checking bench for the three-key record sorter: directed and random record sets against a sorting predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rsk_pkg::*;

    localparam int CAPACITY  = REC_MAX_DEF;
    localparam int RAND_RECS = 250;
    localparam int TAIL_WAIT = 50;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        t_rec_in rec;
        int      gap_pct;
    } t_queued_rec;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_rec_in  rec_in  = '0;
    logic     res_valid;
    t_rec_out res_out;

    t_queued_rec records_pending[$];
    t_rec_out    results_due[$];

    // model of the store
    t_rec held_recs [CAPACITY];
    int   held_count = 0;
    bit   dropped    = 1'b0;

    int records_in    = 0;
    int sets_done     = 0;
    int overflow_sets = 0;
    int results_seen  = 0;
    int mismatches    = 0;
    int rand_recs     = 0;

    record_sorter_three_key #(.MAX_RECORDS(CAPACITY)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (rec_in),
        .o_valid  (res_valid),
        .o_result (res_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // lane up, then car up, then stamp down
    function automatic bit sorts_ahead(input t_rec a, input t_rec b);
        if (a.lane_id != b.lane_id) begin
            return a.lane_id < b.lane_id;
        end
        if (a.car_id != b.car_id) begin
            return a.car_id < b.car_id;
        end
        return a.stamp > b.stamp;
    endfunction

    function automatic void take_record(input t_rec_in it);
        t_rec     r;
        t_rec     tmp;
        t_rec_out res;
        int       n;
        int       lo;
        int       j;
        int       best;
        records_in++;
        if (held_count < CAPACITY) begin
            r.lane_id = it.lane_id;
            r.car_id  = it.car_id;
            r.stamp   = it.stamp;
            r.pos_x   = it.pos_x;
            r.pos_y   = it.pos_y;
            held_recs[held_count] = r;
            held_count++;
        end else begin
            dropped = 1'b1;
        end
        if (!it.last_record) begin
            return;
        end
        n = held_count;
        // earliest strict minimum, then swap: fixes the order of equal keys
        for (lo = 0; lo < n - 1; lo++) begin
            best = lo;
            for (j = lo + 1; j < n; j++) begin
                if (sorts_ahead(held_recs[j], held_recs[best])) begin
                    best = j;
                end
            end
            if (best != lo) begin
                tmp             = held_recs[lo];
                held_recs[lo]   = held_recs[best];
                held_recs[best] = tmp;
            end
        end
        for (j = 0; j < n; j++) begin
            res.out_lane_id = held_recs[j].lane_id;
            res.out_car_id  = held_recs[j].car_id;
            res.out_stamp   = held_recs[j].stamp;
            res.out_pos_x   = held_recs[j].pos_x;
            res.out_pos_y   = held_recs[j].pos_y;
            res.out_last    = (j == n - 1);
            res.overflow    = dropped;
            results_due.push_back(res);
        end
        if (dropped) begin
            overflow_sets++;
        end
        sets_done++;
        held_count = 0;
        dropped    = 1'b0;
    endfunction

    task automatic queue_record(input logic [3:0] lane, input logic [3:0] car,
                                input logic [15:0] stamp, input logic [6:0] px,
                                input logic [5:0] py, input logic last, input int gap_pct);
        t_queued_rec q;
        q.rec.lane_id     = lane;
        q.rec.car_id      = car;
        q.rec.stamp       = stamp;
        q.rec.pos_x       = px;
        q.rec.pos_y       = py;
        q.rec.last_record = last;
        q.gap_pct         = gap_pct;
        records_pending.push_back(q);
    endtask

    // narrow key ranges give plenty of ties, including fully equal keys
    task automatic queue_random_set(input int size, input int gap_pct);
        bit          tight;
        logic [15:0] st;
        tight = 1'($urandom_range(0, 1));
        for (int i = 0; i < size; i++) begin
            if (tight) begin
                case ($urandom_range(0, 3))
                    0: begin
                        st = 16'h0000;
                    end
                    1: begin
                        st = 16'hFFFF;
                    end
                    default: begin
                        st = 16'($urandom_range(0, 3));
                    end
                endcase
                queue_record(4'($urandom_range(0, 2)), 4'($urandom_range(0, 2)), st,
                             7'($urandom), 6'($urandom), i == size - 1, gap_pct);
            end else begin
                queue_record(4'($urandom), 4'($urandom), 16'($urandom), 7'($urandom),
                             6'($urandom), i == size - 1, gap_pct);
            end
        end
        rand_recs += size;
    endtask

    // driver: start stays high until the transaction is taken
    always @(posedge i_clk) begin : drive
        t_queued_rec nxt;
        if (!i_rst_n) begin
            start  <= 1'b0;
            rec_in <= '0;
        end else begin
            if (start && !busy) begin
                take_record(rec_in);
            end
            if (!(start && busy)) begin
                if (records_pending.size() != 0 &&
                    $urandom_range(0, 99) >= records_pending[0].gap_pct) begin
                    nxt = records_pending.pop_front();
                    rec_in <= nxt.rec;
                    start  <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: results cannot be held off, so every strobe is checked
    always @(posedge i_clk) begin : watch
        t_rec_out want;
        bit       bad;
        if (i_rst_n && res_valid) begin
            results_seen++;
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN) begin
                    $display("ERROR %0t: unexpected result lane %0d car %0d stamp %0d",
                             $realtime, res_out.out_lane_id, res_out.out_car_id,
                             res_out.out_stamp);
                end
            end else begin
                want = results_due.pop_front();
                bad  = (res_out.out_lane_id !== want.out_lane_id)
                    || (res_out.out_car_id  !== want.out_car_id)
                    || (res_out.out_stamp   !== want.out_stamp)
                    || (res_out.out_pos_x   !== want.out_pos_x)
                    || (res_out.out_pos_y   !== want.out_pos_y)
                    || (res_out.out_last    !== want.out_last)
                    || (res_out.overflow    !== want.overflow);
                if (bad) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN) begin
                        $display("ERROR %0t: exp lane %0d car %0d st %0d x %0d y %0d l %0b o %0b",
                                 $realtime, want.out_lane_id, want.out_car_id, want.out_stamp,
                                 want.out_pos_x, want.out_pos_y, want.out_last, want.overflow);
                        $display("           got lane %0d car %0d st %0d x %0d y %0d l %0b o %0b",
                                 res_out.out_lane_id, res_out.out_car_id, res_out.out_stamp,
                                 res_out.out_pos_x, res_out.out_pos_y, res_out.out_last,
                                 res_out.overflow);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int phase_gap [3];
        int pick;
        phase_gap[0] = 11;
        phase_gap[1] = 60;
        phase_gap[2] = 0;

        // directed: single records at the field extremes
        queue_record(4'd0, 4'd0, 16'h0000, 7'd0, 6'd0, 1'b1, phase_gap[0]);
        queue_record(4'hF, 4'hF, 16'hFFFF, 7'h7F, 6'h3F, 1'b1, phase_gap[0]);
        // two records that must swap on stamp
        queue_record(4'd5, 4'd5, 16'd10, 7'd1, 6'd1, 1'b0, phase_gap[0]);
        queue_record(4'd5, 4'd5, 16'd20, 7'd2, 6'd2, 1'b1, phase_gap[0]);
        // ties on every key level, fully equal keys with distinct payloads
        queue_record(4'd3, 4'd5, 16'd100, 7'd1, 6'd1, 1'b0, phase_gap[0]);
        queue_record(4'd3, 4'd5, 16'd100, 7'd2, 6'd2, 1'b0, phase_gap[0]);
        queue_record(4'd3, 4'd5, 16'hFFFF, 7'd5, 6'd5, 1'b0, phase_gap[0]);
        queue_record(4'd3, 4'd5, 16'd0, 7'd6, 6'd6, 1'b0, phase_gap[0]);
        queue_record(4'd3, 4'd4, 16'd7, 7'd7, 6'd7, 1'b0, phase_gap[0]);
        queue_record(4'd0, 4'hF, 16'd0, 7'd8, 6'd8, 1'b0, phase_gap[0]);
        queue_record(4'hF, 4'd0, 16'hFFFF, 7'd9, 6'd9, 1'b0, phase_gap[0]);
        queue_record(4'd3, 4'd5, 16'd100, 7'd3, 6'd3, 1'b0, phase_gap[0]);
        queue_record(4'hF, 4'hF, 16'hFFFF, 7'h7F, 6'h3F, 1'b0, phase_gap[0]);
        queue_record(4'd0, 4'd0, 16'd0, 7'd0, 6'd0, 1'b0, phase_gap[0]);
        queue_record(4'd3, 4'd6, 16'd100, 7'd10, 6'd10, 1'b0, phase_gap[0]);
        queue_record(4'd3, 4'd5, 16'd100, 7'd4, 6'd4, 1'b1, phase_gap[0]);

        // random sets: each phase opens with a full or overfull set
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    queue_random_set(CAPACITY, phase_gap[ph]);
                end
                1: begin
                    // the closing record itself is dropped
                    queue_random_set(CAPACITY + 1, phase_gap[ph]);
                end
                default: begin
                    queue_random_set(CAPACITY + $urandom_range(2, 4), phase_gap[ph]);
                end
            endcase
            while (rand_recs < RAND_RECS * (ph + 1) / 3) begin
                pick = $urandom_range(0, 9);
                if (pick < 8) begin
                    queue_random_set($urandom_range(1, 8), phase_gap[ph]);
                end else if (pick == 8) begin
                    queue_random_set($urandom_range(9, CAPACITY - 1), phase_gap[ph]);
                end else begin
                    queue_random_set($urandom_range(CAPACITY, CAPACITY + 4), phase_gap[ph]);
                end
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (records_pending.size() != 0 || start || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_WAIT) @(posedge i_clk);

        $display("Sorted %0d sets from %0d records (%0d sets overfull), checked %0d results.",
                 sets_done, records_in, overflow_sets, results_seen);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("record_sorter_three_key test passed");
        end else begin
            $display("record_sorter_three_key test failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2000000;
        $display("Timed out with %0d results outstanding", results_due.size());
        $display("record_sorter_three_key test failed");
        $finish;
    end

endmodule
